// File: rtl/gct_pkg.sv
// Shared types and constants for the grid clearance transform.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package gct_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_MAX_LAND   = 2'd2,
    REG_MAX_AIR    = 2'd3
  } cfg_reg_e;

  // Map geometry
  localparam int MAX_HEIGHT   = 1024;
  localparam int ROW_W        = 10;
  localparam int EDGE_CELLS   = 2;
  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 1024;

  // Field widths at the ports
  localparam int CAP_W       = 4;
  localparam int OUT_CLEAR_W = 4;
  localparam int OUT_COORD_W = 10;

  localparam logic [CAP_W-1:0] RESET_CAP = 4'd1;

endpackage

`default_nettype wire

// File: rtl/gct_line_buf.sv
// Line buffer holding the packed land/air values of the row below.
// One write port, one read port with registered read data; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gct_line_buf #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/grid_clearance_transform.sv
// Top level of the grid clearance transform: scan counters, clearance logic,
// output register. Depends on gct_pkg and gct_line_buf.
`timescale 1ns / 1ps
`default_nettype none

// Takes one land-blocked bit per cell in reverse raster order (bottom row first,
// each row right to left) and returns, one beat per cell, the land and air
// clearance with the cell's coordinates; map_done marks the top-left cell. The
// block takes one cell every clock cycle unless in_stall_o holds it off, and each
// result appears in the output register in the cycle after its cell is accepted.
// The line buffer is read one cell ahead of the scan, so its single read port and
// single write port carry one cell per cycle. Writing map_width or map_height
// restarts the scan at the bottom-right cell; caps apply from the next cell on.
// Write configuration only while no result is pending.
module grid_clearance_transform
  import gct_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int CLEAR_BITS = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // cell input
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic                   land_blocked_i,
  // result output
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic [OUT_CLEAR_W-1:0] land_clearance_o,
  output      logic [OUT_CLEAR_W-1:0] air_clearance_o,
  output      logic [OUT_COORD_W-1:0] cell_column_o,
  output      logic [OUT_COORD_W-1:0] cell_row_o,
  output      logic                   map_done_o,
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output      logic                   cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CB      = CLEAR_BITS;
  localparam int CMP_W   = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;
  localparam int RST_W   = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;
  localparam logic [CB+CAP_W-1:0] CLEAR_MASK = (CB + CAP_W)'((1 << CB) - 1);

  // Configuration and scan state
  logic [COL_W-1:0] wm1_q, wm1_d;
  logic [ROW_W-1:0] hm1_q, hm1_d;
  logic [CAP_W-1:0] cap_land_q, cap_land_d;
  logic [CAP_W-1:0] cap_air_q, cap_air_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CB-1:0]    east_land_q, east_land_d;
  logic [CB-1:0]    east_air_q, east_air_d;
  logic [2*CB-1:0]  se_q, se_d;

  // Output register
  logic             out_valid_q;
  logic [CB-1:0]    out_land_q, out_air_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic             out_done_q;

  logic             in_acc;
  logic             cfg_we;
  logic [2*CB-1:0]  south;
  logic [CB-1:0]    land, air;
  logic             interior;
  logic [CB-1:0]    cap_land_eff, cap_air_eff;
  logic [COL_W-1:0] wm1_new;
  logic [ROW_W-1:0] hm1_new;
  logic [CMP_W-1:0] w_ext;

  function automatic logic [CB-1:0] limit_cap(input logic [CAP_W-1:0] cap);
    logic [CB+CAP_W-1:0] ext;
    ext = (CB + CAP_W)'(cap);
    if (ext > CLEAR_MASK) begin
      return CLEAR_MASK[CB-1:0];
    end
    return ext[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] grow(input logic [CB-1:0] a,
                                         input logic [CB-1:0] b,
                                         input logic [CB-1:0] c,
                                         input logic [CB-1:0] cap);
    logic [CB-1:0] m;
    logic [CB:0]   inc;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    inc = {1'b0, m} + (CB + 1)'(1);
    return (inc > {1'b0, cap}) ? cap : inc[CB-1:0];
  endfunction

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // Clamp written dimensions to the supported range, kept as size minus one
  assign w_ext = CMP_W'(cfg_data_i);

  always_comb begin
    if (w_ext == '0) begin
      wm1_new = '0;
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      wm1_new = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1_new = COL_W'(w_ext - CMP_W'(1));
    end
    if (cfg_data_i == '0) begin
      hm1_new = '0;
    end else if (cfg_data_i > CFG_DATA_W'(MAX_HEIGHT)) begin
      hm1_new = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1_new = ROW_W'(cfg_data_i - CFG_DATA_W'(1));
    end
  end

  // Clearance of the current cell
  assign cap_land_eff = limit_cap(cap_land_q);
  assign cap_air_eff  = limit_cap(cap_air_q);
  assign interior =
      (({1'b0, col_q} + (COL_W + 1)'(EDGE_CELLS)) <= {1'b0, wm1_q}) &&
      (({1'b0, row_q} + (ROW_W + 1)'(EDGE_CELLS)) <= {1'b0, hm1_q});

  always_comb begin
    land = '0;
    air  = '0;
    if (interior) begin
      if (!land_blocked_i) begin
        land = grow(south[CB-1:0], se_q[CB-1:0], east_land_q, cap_land_eff);
      end
      air = grow(south[2*CB-1:CB], se_q[2*CB-1:CB], east_air_q, cap_air_eff);
    end
  end

  // Next state: scan advance on a beat, restart on a dimension write, cap update on a cap write
  always_comb begin
    wm1_d       = wm1_q;
    hm1_d       = hm1_q;
    cap_land_d  = cap_land_q;
    cap_air_d   = cap_air_q;
    col_d       = col_q;
    row_d       = row_q;
    east_land_d = east_land_q;
    east_air_d  = east_air_q;
    se_d        = se_q;

    if (in_acc) begin
      se_d        = south;
      east_land_d = land;
      east_air_d  = air;
      if (col_q == '0) begin
        col_d = wm1_q;
        row_d = (row_q == '0) ? hm1_q : row_q - ROW_W'(1);
      end else begin
        col_d = col_q - COL_W'(1);
      end
    end

    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MAP_WIDTH: begin
          wm1_d       = wm1_new;
          col_d       = wm1_new;
          row_d       = hm1_q;
          east_land_d = '0;
          east_air_d  = '0;
          se_d        = '0;
        end
        REG_MAP_HEIGHT: begin
          hm1_d       = hm1_new;
          col_d       = wm1_q;
          row_d       = hm1_new;
          east_land_d = '0;
          east_air_d  = '0;
          se_d        = '0;
        end
        REG_MAX_LAND: cap_land_d = cfg_data_i[CAP_W-1:0];
        REG_MAX_AIR:  cap_air_d  = cfg_data_i[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q       <= COL_W'(RST_W - 1);
      hm1_q       <= ROW_W'(RESET_HEIGHT - 1);
      cap_land_q  <= RESET_CAP;
      cap_air_q   <= RESET_CAP;
      col_q       <= COL_W'(RST_W - 1);
      row_q       <= ROW_W'(RESET_HEIGHT - 1);
      east_land_q <= '0;
      east_air_q  <= '0;
      se_q        <= '0;
    end else begin
      wm1_q       <= wm1_d;
      hm1_q       <= hm1_d;
      cap_land_q  <= cap_land_d;
      cap_air_q   <= cap_air_d;
      col_q       <= col_d;
      row_q       <= row_d;
      east_land_q <= east_land_d;
      east_air_q  <= east_air_d;
      se_q        <= se_d;
    end
  end

  // Read one cell ahead: the address is the column the scan moves to
  gct_line_buf #(
    .DEPTH (MAX_WIDTH),
    .DATA_W(2 * CB)
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(col_q),
    .wdata_i({air, land}),
    .raddr_i(col_d),
    .rdata_o(south)
  );

  // Output register: refill whenever the held beat leaves or none is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_land_q <= land;
      out_air_q  <= air;
      out_col_q  <= col_q;
      out_row_q  <= row_q;
      out_done_q <= (col_q == '0) && (row_q == '0);
    end
  end

  logic [CB+OUT_CLEAR_W-1:0]    land_ext, air_ext;
  logic [COL_W+OUT_COORD_W-1:0] col_ext;

  assign land_ext = (CB + OUT_CLEAR_W)'(out_land_q);
  assign air_ext  = (CB + OUT_CLEAR_W)'(out_air_q);
  assign col_ext  = (COL_W + OUT_COORD_W)'(out_col_q);

  assign out_valid_o      = out_valid_q;
  assign land_clearance_o = land_ext[OUT_CLEAR_W-1:0];
  assign air_clearance_o  = air_ext[OUT_CLEAR_W-1:0];
  assign cell_column_o    = col_ext[OUT_COORD_W-1:0];
  assign cell_row_o       = out_row_q;
  assign map_done_o       = out_done_q;

`ifndef SYNTH
  a_col_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wm1_q)
    else $error("scan column beyond map width");

  a_row_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= hm1_q)
    else $error("scan row beyond map height");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cfg_we && col_q != '0 |=> col_q == $past(col_q) - COL_W'(1))
    else $error("scan column did not step left");

  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && map_done_o |-> cell_column_o == '0 && cell_row_o == '0)
    else $error("map_done on a cell other than the origin");
`endif

endmodule

`default_nettype wire

// File: sim/tb_grid_clearance_transform.sv
// Self-checking testbench for grid_clearance_transform: streams cell maps through the block and
// checks every result beat against an in-bench clearance predictor.
// Depends on gct_pkg and the grid_clearance_transform RTL.
`timescale 1ns / 1ps

module tb_grid_clearance_transform;
  import gct_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int CLEAR_BITS    = 4;
  localparam int LONG_HOLD     = 300;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int RANDOM_PHASE  = 360;

  typedef struct packed {
    logic [OUT_CLEAR_W-1:0] land;
    logic [OUT_CLEAR_W-1:0] air;
    logic [OUT_COORD_W-1:0] col;
    logic [OUT_COORD_W-1:0] row;
    logic                   done;
  } clearance_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   land_blocked_i = 1'b0;
  logic                   out_stall_i = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  wire                    in_stall_o;
  wire                    out_valid_o;
  wire                    cfg_ready_o;
  wire [OUT_CLEAR_W-1:0]  land_clearance_o;
  wire [OUT_CLEAR_W-1:0]  air_clearance_o;
  wire [OUT_COORD_W-1:0]  cell_column_o;
  wire [OUT_COORD_W-1:0]  cell_row_o;
  wire                    map_done_o;

  grid_clearance_transform DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .land_blocked_i   (land_blocked_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .land_clearance_o (land_clearance_o),
    .air_clearance_o  (air_clearance_o),
    .cell_column_o    (cell_column_o),
    .cell_row_o       (cell_row_o),
    .map_done_o       (map_done_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: configuration mirror, line buffer and scan position
  logic [CFG_DATA_W-1:0]   map_width_r;
  logic [CFG_DATA_W-1:0]   map_height_r;
  logic [CAP_W-1:0]        land_cap_r;
  logic [CAP_W-1:0]        air_cap_r;
  logic [2*CLEAR_BITS-1:0] south_row [MAX_WIDTH];
  logic [CLEAR_BITS-1:0]   east_land;
  logic [CLEAR_BITS-1:0]   east_air;
  logic [2*CLEAR_BITS-1:0] southeast_pair;
  int unsigned             scan_col;
  int unsigned             scan_row;

  clearance_t  expected_clearances[$];
  logic        pending_cells[$];
  int unsigned cells_queued = 0;
  int unsigned cells_sent = 0;
  int unsigned errors = 0;
  int unsigned src_idle_pct = 27;
  int unsigned sink_stall_pct = 81;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned used_width();
    if (map_width_r == 0) return 1;
    if (map_width_r > MAX_WIDTH) return MAX_WIDTH;
    return int'(map_width_r);
  endfunction

  function automatic int unsigned used_height();
    if (map_height_r == 0) return 1;
    if (map_height_r > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(map_height_r);
  endfunction

  function automatic void restart_scan();
    scan_col = used_width() - 1;
    scan_row = used_height() - 1;
    east_land = '0;
    east_air = '0;
    southeast_pair = '0;
  endfunction

  function automatic logic [CLEAR_BITS-1:0] min_of_three(input logic [CLEAR_BITS-1:0] a,
                                                          input logic [CLEAR_BITS-1:0] b,
                                                          input logic [CLEAR_BITS-1:0] c);
    logic [CLEAR_BITS-1:0] m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  function automatic logic [CLEAR_BITS-1:0] grow_capped(input logic [CLEAR_BITS-1:0] m,
                                                         input logic [CAP_W-1:0] cap);
    logic [CLEAR_BITS:0] n;
    n = {1'b0, m} + (CLEAR_BITS + 1)'(1);
    return (n > cap) ? cap : n[CLEAR_BITS-1:0];
  endfunction

  function automatic void apply_config(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MAP_WIDTH: begin
        map_width_r = val;
        restart_scan();
      end
      REG_MAP_HEIGHT: begin
        map_height_r = val;
        restart_scan();
      end
      REG_MAX_LAND: land_cap_r = val[CAP_W-1:0];
      REG_MAX_AIR: air_cap_r = val[CAP_W-1:0];
      default: ;
    endcase
  endfunction

  // Work out the clearance of the cell at the scan position and advance the scan
  function automatic void predict_clearance(input logic blocked);
    int unsigned             w, h, x, y;
    logic [2*CLEAR_BITS-1:0] south;
    logic [CLEAR_BITS-1:0]   land, air;
    clearance_t              e;
    w = used_width();
    h = used_height();
    x = scan_col;
    y = scan_row;
    if (x >= w) x = w - 1;
    if (y >= h) y = h - 1;
    south = south_row[x];
    land = '0;
    air = '0;
    if (x + EDGE_CELLS < w && y + EDGE_CELLS < h) begin
      if (!blocked)
        land = grow_capped(min_of_three(south[CLEAR_BITS-1:0],
                                        southeast_pair[CLEAR_BITS-1:0], east_land), land_cap_r);
      air = grow_capped(min_of_three(south[2*CLEAR_BITS-1:CLEAR_BITS],
                                     southeast_pair[2*CLEAR_BITS-1:CLEAR_BITS], east_air),
                        air_cap_r);
    end
    southeast_pair = south;
    south_row[x] = {air, land};
    east_land = land;
    east_air = air;
    e.land = land;
    e.air = air;
    e.col = x[OUT_COORD_W-1:0];
    e.row = y[OUT_COORD_W-1:0];
    e.done = (x == 0 && y == 0);
    expected_clearances.insert(expected_clearances.size(), e);
    if (x == 0) begin
      scan_col = w - 1;
      scan_row = (y == 0) ? h - 1 : y - 1;
    end else begin
      scan_col = x - 1;
      scan_row = y;
    end
  endfunction

  // Cell driver: predict on every accepted beat, hold a stalled beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_clearance(land_blocked_i);
        cells_sent <= cells_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cells.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid_i <= 1'b1;
          land_blocked_i <= pending_cells.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          land_blocked_i <= 1'($urandom_range(1));
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk_i) begin : result_monitor
    clearance_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {land_clearance_o, air_clearance_o, cell_column_o, cell_row_o, map_done_o};
        if (expected_clearances.size() == 0) begin
          $display("%0t: unexpected beat land %0d air %0d col %0d row %0d done %0b",
                   $time, got.land, got.air, got.col, got.row, got.done);
          errors <= errors + 1;
        end else begin
          want = expected_clearances.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected land %0d air %0d col %0d row %0d done %0b",
                     $time, want.land, want.air, want.col, want.row, want.done);
            $display("%0t:            actual land %0d air %0d col %0d row %0d done %0b",
                     $time, got.land, got.air, got.col, got.row, got.done);
            errors <= errors + 1;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
        out_stall_i <= 1'b1;
        hold_left <= LONG_HOLD;
        hold_served <= hold_served + 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no useful beat; stray result beats after an error do not count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i && errors == 0) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_config(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup_map(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CAP_W-1:0] land_cap, input logic [CAP_W-1:0] air_cap);
    logic [CFG_DATA_W-CAP_W-1:0] junk;
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    // upper data bits are ignored for caps; toggle them anyway
    junk = (CFG_DATA_W - CAP_W)'($urandom);
    write_reg(REG_MAX_LAND, {junk, land_cap});
    junk = (CFG_DATA_W - CAP_W)'($urandom);
    write_reg(REG_MAX_AIR, {junk, air_cap});
  endtask

  // Queue cells, then wait until every one of them has come back
  task automatic feed_cells(input int unsigned count, input int unsigned blocked_pct);
    for (int unsigned i = 0; i < count; i++) begin
      pending_cells.insert(pending_cells.size(), ($urandom_range(99) < blocked_pct));
      cells_queued++;
    end
    do @(posedge clk_i); while (cells_sent != cells_queued || expected_clearances.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CAP_W-1:0] pick_cap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 4'd15;
    if (r < 35) return 4'd0;
    return CAP_W'($urandom_range(15));
  endfunction

  task automatic run_random_maps(input int unsigned target);
    int unsigned fed, r, count, density;
    logic [CFG_DATA_W-1:0] w, h;
    fed = 0;
    while (fed < target) begin
      r = $urandom_range(99);
      if (r < 65) begin
        w = CFG_DATA_W'($urandom_range(10, 3));
        h = CFG_DATA_W'($urandom_range(8, 3));
      end else if (r < 85) begin
        w = CFG_DATA_W'($urandom_range(20, 14));
        h = CFG_DATA_W'($urandom_range(20, 14));
      end else begin
        case ($urandom_range(5))
          0: w = 11'd0;
          1: w = 11'd1;
          2: w = 11'd2;
          3: w = 11'd3;
          4: w = 11'd1024;
          default: w = 11'd2047;
        endcase
        h = CFG_DATA_W'($urandom_range(4));
      end
      setup_map(w, h, pick_cap(), pick_cap());
      count = used_width() * used_height() * $urandom_range(2, 1);
      if (count > 450) count = $urandom_range(60, 20);
      else if ($urandom_range(9) == 0) count = $urandom_range(count, 1);
      case ($urandom_range(4))
        0: density = 0;
        1: density = 5;
        2: density = 15;
        3: density = 40;
        default: density = 100;
      endcase
      feed_cells(count, density);
      fed += count;
    end
  endtask

  initial begin
    map_width_r = RESET_WIDTH;
    map_height_r = RESET_HEIGHT;
    land_cap_r = RESET_CAP;
    air_cap_r = RESET_CAP;
    for (int i = 0; i < MAX_WIDTH; i++) south_row[i] = '0;
    restart_scan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset geometry, 3x3 map, caps at both extremes, scan wrap
    feed_cells(4, 50);
    setup_map(11'd3, 11'd3, 4'd15, 4'd15);
    feed_cells(9, 0);
    setup_map(11'd3, 11'd3, 4'd0, 4'd15);
    feed_cells(12, 50);

    // Random, sender mostly busy and receiver mostly stalled; start with clamped dimensions
    setup_map(11'd2047, 11'd2047, 4'd15, 4'd15);
    feed_cells(40, 20);
    run_random_maps(RANDOM_PHASE);

    src_idle_pct = 81;
    sink_stall_pct = 27;
    run_random_maps(RANDOM_PHASE);

    // No idling; hold the receiver off long enough to back up the input
    src_idle_pct = 0;
    sink_stall_pct = 0;
    setup_map(11'd20, 11'd20, 4'd15, 4'd15);
    hold_requests++;
    feed_cells(400, 5);
    run_random_maps(RANDOM_PHASE);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
